// ===== rtl/sgpf_pkg.sv =====
// Shared types and constants for the slope ground point filter.
// No dependencies; imported by every module of the block but sgpf_fifo.
`timescale 1ns / 1ps

package sgpf_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned SlopeW  = 16;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned DiffW   = CoordW + 1;       // full-width difference
  localparam int unsigned SqW     = 2 * CoordW;       // one squared magnitude
  localparam int unsigned Dist2W  = SqW + 1;          // sum of two squares
  localparam int unsigned SlopeSqW = 2 * SlopeW - 1;  // |limit|^2 <= 2^30

  localparam logic [CfgIdxW-1:0] RegSlopeLimit  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegFloorHeight = 1'b1;

  localparam logic signed [CoordW-1:0] CoordInf = 32'sh7FFF_FFFF;
  localparam logic signed [SlopeW-1:0] SlopeLimitRst  = 16'sd256;
  localparam logic signed [CoordW-1:0] FloorHeightRst = 32'sd3277;

  typedef struct packed {
    logic                     column_start;
    logic signed [CoordW-1:0] raw_x;
    logic signed [CoordW-1:0] raw_y;
    logic signed [CoordW-1:0] raw_z;
    logic signed [CoordW-1:0] map_x;
    logic signed [CoordW-1:0] map_y;
    logic signed [CoordW-1:0] map_z;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic signed [CoordW-1:0] out_z;
    logic                     is_ground;
    logic                     passed_raw;
  } out_item_t;

  // Classified point handed from front to back.
  typedef struct packed {
    logic signed [CoordW-1:0] pt_x;
    logic signed [CoordW-1:0] pt_y;
    logic signed [CoordW-1:0] pt_z;
    logic                     too_close;
    logic                     dz_neg;
    logic [CoordW-1:0]        dz_mag;
    logic [Dist2W-1:0]        dist2;
  } mid_item_t;

  function automatic logic [CoordW-1:0] diff_mag(input logic signed [DiffW-1:0] v);
    logic [DiffW-1:0] n;
    n = v[DiffW-1] ? (~v + 1'b1) : v;
    return n[CoordW-1:0];
  endfunction

endpackage

// ===== rtl/slope_ground_point_filter.sv =====
// Slope ground point filter: one point in, one point out. The front end takes a
// point and works through its difference, squares, sum and compare steps before
// it can take the next, since each point's distance test decides the kept point
// the next one is measured from; it holds the point while the middle queue is full.
// The back end does the slope multiply and compare, and
// two 2-entry queues let either side stall without blocking the other.
// Depends on sgpf_pkg, sgpf_front, sgpf_back and sgpf_fifo.
`timescale 1ns / 1ps

module slope_ground_point_filter import sgpf_pkg::*; #(
  parameter int unsigned COORD_FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  in_item_t           in_item_i,
  output logic               full_o,
  input  logic               pop_i,
  output out_item_t          out_item_o,
  output logic               empty_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  logic signed [SlopeW-1:0] slope_limit_q;
  logic signed [CoordW-1:0] floor_height_q;

  logic      mid_push, mid_full, mid_pop, mid_empty;
  mid_item_t mid_in, mid_out;
  logic      res_push, res_full;
  out_item_t res_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slope_limit_q  <= SlopeLimitRst;
      floor_height_q <= FloorHeightRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegSlopeLimit:  slope_limit_q  <= cfg_wdata_i[SlopeW-1:0];
        RegFloorHeight: floor_height_q <= cfg_wdata_i[CoordW-1:0];
        default: ;
      endcase
    end
  end

  sgpf_front #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .in_item_i  (in_item_i),
    .full_o     (full_o),
    .mid_push_o (mid_push),
    .mid_item_o (mid_in),
    .mid_full_i (mid_full)
  );

  sgpf_fifo #(
    .item_t(mid_item_t),
    .DEPTH (2)
  ) u_mid_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (mid_push),
    .data_i (mid_in),
    .full_o (mid_full),
    .pop_i  (mid_pop),
    .data_o (mid_out),
    .empty_o(mid_empty)
  );

  sgpf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mid_item_i     (mid_out),
    .mid_empty_i    (mid_empty),
    .mid_pop_o      (mid_pop),
    .slope_limit_i  (slope_limit_q),
    .floor_height_i (floor_height_q),
    .out_push_o     (res_push),
    .out_item_o     (res_item),
    .out_full_i     (res_full)
  );

  sgpf_fifo #(
    .item_t(out_item_t),
    .DEPTH (2)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_item),
    .full_o (res_full),
    .pop_i  (pop_i),
    .data_o (out_item_o),
    .empty_o(empty_o)
  );

endmodule

// ===== rtl/sgpf_fifo.sv =====
// Small register queue used between front and back and at the result side.
// Depends on nothing but its type parameter.
`timescale 1ns / 1ps

module sgpf_fifo #(
  parameter type         item_t = logic,
  parameter int unsigned DEPTH  = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t data_o,
  output logic  empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  item_t           mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_wr   = push_i && !full_o;
  assign do_rd   = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_wr && do_rd) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/sgpf_front.sv =====
// Front end: takes points, tracks the kept point and decides "too close".
// Depends on sgpf_pkg.
`timescale 1ns / 1ps

module sgpf_front import sgpf_pkg::*; #(
  parameter int unsigned COORD_FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  in_item_t  in_item_i,
  output logic      full_o,
  output logic      mid_push_o,
  output mid_item_t mid_item_o,
  input  logic      mid_full_i
);

  // Run below 0.0001 m: d2 * 10^8 < 2^(2F), i.e. d2 <= (2^(2F)-1) / 10^8.
  localparam logic [SqW-1:0] CloseMax =
    ((64'd1 << (2 * COORD_FRAC_BITS)) - 64'd1) / 64'd100000000;

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StSquare = 3'b010,
    StDecide = 3'b100
  } front_state_e;

  front_state_e state_q, state_d;

  logic signed [CoordW-1:0] prev_x_q, prev_y_q, prev_z_q;
  in_item_t                 item_q;
  logic signed [DiffW-1:0]  dx_q, dy_q, dz_q;
  logic [SqW-1:0]           sx_q, sy_q;
  logic [CoordW-1:0]        az_q;
  logic                     dz_neg_q;

  logic signed [CoordW-1:0] base_x, base_y, base_z;
  logic [CoordW-1:0]        ax, ay;
  logic [Dist2W-1:0]        dist2;
  logic                     too_close;
  logic                     accept, emit;

  assign full_o = (state_q != StIdle);
  assign accept = push_i && (state_q == StIdle);
  assign emit   = (state_q == StDecide) && !mid_full_i;

  // A column start puts the kept point back to the origin.
  assign base_x = in_item_i.column_start ? '0 : prev_x_q;
  assign base_y = in_item_i.column_start ? '0 : prev_y_q;
  assign base_z = in_item_i.column_start ? '0 : prev_z_q;

  assign ax = diff_mag(dx_q);
  assign ay = diff_mag(dy_q);

  assign dist2     = {1'b0, sx_q} + {1'b0, sy_q};
  assign too_close = (dist2 <= {1'b0, CloseMax});

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (push_i) state_d = StSquare;
      StSquare: state_d = StDecide;
      StDecide: if (!mid_full_i) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_comb begin
    mid_item_o.pt_x      = too_close ? item_q.raw_x : item_q.map_x;
    mid_item_o.pt_y      = too_close ? item_q.raw_y : item_q.map_y;
    mid_item_o.pt_z      = too_close ? item_q.raw_z : item_q.map_z;
    mid_item_o.too_close = too_close;
    mid_item_o.dz_neg    = dz_neg_q;
    mid_item_o.dz_mag    = az_q;
    mid_item_o.dist2     = dist2;
  end
  assign mid_push_o = emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      prev_x_q <= '0;
      prev_y_q <= '0;
      prev_z_q <= '0;
    end else begin
      state_q <= state_d;
      if (accept && in_item_i.column_start) begin
        prev_x_q <= '0;
        prev_y_q <= '0;
        prev_z_q <= '0;
      end else if (emit && !too_close) begin
        prev_x_q <= item_q.map_x;
        prev_y_q <= item_q.map_y;
        prev_z_q <= item_q.map_z;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
      dx_q   <= DiffW'(in_item_i.map_x) - DiffW'(base_x);
      dy_q   <= DiffW'(in_item_i.map_y) - DiffW'(base_y);
      dz_q   <= DiffW'(in_item_i.map_z) - DiffW'(base_z);
    end
    if (state_q == StSquare) begin
      sx_q     <= ax * ax;
      sy_q     <= ay * ay;
      az_q     <= diff_mag(dz_q);
      dz_neg_q <= dz_q[DiffW-1];
    end
  end

endmodule

// ===== rtl/sgpf_back.sv =====
// Back end: exact slope compare on squared products and result forming.
// Depends on sgpf_pkg.
`timescale 1ns / 1ps

module sgpf_back import sgpf_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mid_item_t                mid_item_i,
  input  logic                     mid_empty_i,
  output logic                     mid_pop_o,
  input  logic signed [SlopeW-1:0] slope_limit_i,
  input  logic signed [CoordW-1:0] floor_height_i,
  output logic                     out_push_o,
  output out_item_t                out_item_o,
  input  logic                     out_full_i
);

  localparam int unsigned LoW   = Dist2W / 2;
  localparam int unsigned HiW   = Dist2W - LoW;
  localparam int unsigned CmpW  = Dist2W + SlopeSqW;

  logic [SlopeW-1:0]           lim_mag;
  logic [SlopeSqW-1:0]         t2_q;
  logic                        lim_neg_q;

  logic                        b1_valid_q;
  logic signed [CoordW-1:0]    pt_x_q, pt_y_q, pt_z_q;
  logic                        close_q, dz_neg_q;
  logic [SqW-1:0]              p_q;
  logic [LoW+SlopeSqW-1:0]     rl_q;
  logic [HiW+SlopeSqW-1:0]     rh_q;

  logic [CmpW-1:0]             lhs, rhs;
  logic                        ground, advance, load;

  logic [SlopeW:0] lim_neg_ext;
  assign lim_neg_ext = ~{slope_limit_i[SlopeW-1], slope_limit_i} + 1'b1;
  assign lim_mag = slope_limit_i[SlopeW-1] ? lim_neg_ext[SlopeW-1:0] : slope_limit_i;

  assign advance    = b1_valid_q && !out_full_i;
  assign load       = !mid_empty_i && (!b1_valid_q || advance);
  assign mid_pop_o  = load;
  assign out_push_o = advance;

  // dz^2 * 256^2 against d^2 * limit^2
  assign lhs = CmpW'({p_q, 16'h0000});
  assign rhs = CmpW'(rl_q) + (CmpW'(rh_q) << LoW);

  always_comb begin
    if (!lim_neg_q) begin
      ground = dz_neg_q || (lhs < rhs);
    end else begin
      ground = dz_neg_q && (rhs < lhs);
    end
  end

  always_comb begin
    priority if (close_q) begin
      out_item_o.out_x      = pt_x_q;
      out_item_o.out_y      = pt_y_q;
      out_item_o.out_z      = pt_z_q;
      out_item_o.is_ground  = 1'b0;
      out_item_o.passed_raw = 1'b1;
    end else if (ground) begin
      out_item_o.out_x      = CoordInf;
      out_item_o.out_y      = CoordInf;
      out_item_o.out_z      = floor_height_i;
      out_item_o.is_ground  = 1'b1;
      out_item_o.passed_raw = 1'b0;
    end else begin
      out_item_o.out_x      = pt_x_q;
      out_item_o.out_y      = pt_y_q;
      out_item_o.out_z      = pt_z_q;
      out_item_o.is_ground  = 1'b0;
      out_item_o.passed_raw = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
    end else if (load) begin
      b1_valid_q <= 1'b1;
    end else if (advance) begin
      b1_valid_q <= 1'b0;
    end
  end

  // limit^2 follows the register in the next cycle; write the limit only while idle, the block does not enforce it
  always_ff @(posedge clk_i) begin
    t2_q      <= SlopeSqW'(lim_mag * lim_mag);
    lim_neg_q <= slope_limit_i[SlopeW-1];
    if (load) begin
      pt_x_q   <= mid_item_i.pt_x;
      pt_y_q   <= mid_item_i.pt_y;
      pt_z_q   <= mid_item_i.pt_z;
      close_q  <= mid_item_i.too_close;
      dz_neg_q <= mid_item_i.dz_neg;
      p_q      <= mid_item_i.dz_mag * mid_item_i.dz_mag;
      rl_q     <= mid_item_i.dist2[LoW-1:0] * t2_q;
      rh_q     <= mid_item_i.dist2[Dist2W-1:LoW] * t2_q;
    end
  end

endmodule

// ===== rtl/sgpf_checker.sv =====
// Port-level checks for the slope ground point filter, bound to the top level.
// Depends on sgpf_pkg and slope_ground_point_filter.
`timescale 1ns / 1ps

module sgpf_checker import sgpf_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      push_i,
  input logic      full_o,
  input logic      pop_i,
  input logic      empty_o,
  input out_item_t out_item_o
);

  // front works on one item at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !full_o |=> full_o)
    else $error("front took an item without going busy");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> !(out_item_o.is_ground && out_item_o.passed_raw))
    else $error("item marked both ground and passed raw");

  a_ground_xy_inf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && out_item_o.is_ground |->
      out_item_o.out_x == CoordInf && out_item_o.out_y == CoordInf)
    else $error("ground item without saturated x and y");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !pop_i |=> !empty_o && $stable(out_item_o))
    else $error("waiting result changed or vanished");

endmodule

bind slope_ground_point_filter sgpf_checker u_sgpf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push_i     (push_i),
  .full_o     (full_o),
  .pop_i      (pop_i),
  .empty_o    (empty_o),
  .out_item_o (out_item_o)
);
